### hdl/aesenc_pkg.sv
// Shared constants, types and round functions for the AES encrypt unit.
package aesenc_pkg;

  localparam int SCHED_WORDS_DEF = 60;
  localparam int NR_MAX          = 14;
  localparam int STAGES          = NR_MAX + 1;
  localparam int CNT_W           = 6;
  localparam int CFG_IDX_W       = 3;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_A    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_B    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_C    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_D    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_SIZE = 3'd4;

  localparam logic [1:0] SIZE_128 = 2'd0;
  localparam logic [1:0] SIZE_192 = 2'd1;
  localparam logic [1:0] SIZE_256 = 2'd2;

  localparam logic [3:0] NR_128 = 4'd10;
  localparam logic [3:0] NR_192 = 4'd12;
  localparam logic [3:0] NR_256 = 4'd14;

  typedef enum logic [1:0] {
    KS_LOAD,
    KS_RUN,
    KS_DONE
  } ks_state_t;

  localparam logic [7:0] SBOX_TAB [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX_TAB[w[31:24]], SBOX_TAB[w[23:16]], SBOX_TAB[w[15:8]], SBOX_TAB[w[7:0]]};
  endfunction

  // Byte 0 of the state sits in the top bits.
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(r + 4*c) -: 8] = SBOX_TAB[s[127 - 8*(r + 4*((c + r) % 4)) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0  = s[127 - 32*c -: 8];
      a1  = s[119 - 32*c -: 8];
      a2  = s[111 - 32*c -: 8];
      a3  = s[103 - 32*c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32*c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[119 - 32*c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[111 - 32*c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[103 - 32*c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

endpackage

### hdl/aes_block_encrypt_unit.sv
// AES-128/192/256 block encrypt unit: key expansion sequencer and unrolled round pipeline.
//
// Usage:
//  - Configuration: write key_word_a..d and key_size through cfg_write,
//    cfg_index and cfg_data while no word is in flight. Every write to one
//    of these registers restarts the key expansion, which loads the key words
//    and then fills the round-key store one 32-bit word per cycle. in_stall
//    stays high while the expansion runs. An unusable key size skips the
//    expansion and every word then comes out with key_error set and a zero
//    ciphertext.
//  - Input channel: plain_high/plain_low, accepted when in_valid is high and
//    in_stall is low. One word per cycle when expanded and not stalled.
//  - Output channel: cipher_high/cipher_low/key_error, taken when out_valid
//    is high and out_stall is low.
//  - Pipeline: the same path to out_valid for every key size; the
//    round pipeline has a fixed 15 register stages (initial key add plus 14
//    round slots, shorter keys pass through the unused tail slots).
//  - Throughput: one word per cycle from the unrolled stages, barring stalls.
//  - Stall: a stalled output word freezes the whole pipeline; in_stall rises
//    in the same cycle, so nothing is lost or repeated.
//  - Reset: clears pipeline valid bits and key registers, then the zero key
//    (128-bit size) is expanded before the first word is taken.
module aes_block_encrypt_unit
  import aesenc_pkg::*;
#(
  parameter int SCHEDULE_WORDS = SCHED_WORDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [63:0]          plain_high,
  input  logic [63:0]          plain_low,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [63:0]          cipher_high,
  output logic [63:0]          cipher_low,
  output logic                 key_error
);

  localparam int AW    = $clog2(SCHEDULE_WORDS);
  localparam int NROWS = SCHEDULE_WORDS / 4;

  // Configuration registers.
  logic [63:0] key_word_a, key_word_b, key_word_c, key_word_d;
  logic [1:0]  key_size;
  logic        cfg_hit;

  always_comb begin
    unique case (cfg_index) inside
      REG_KEY_A, REG_KEY_B, REG_KEY_C, REG_KEY_D, REG_KEY_SIZE: cfg_hit = 1'b1;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_word_a <= '0;
      key_word_b <= '0;
      key_word_c <= '0;
      key_word_d <= '0;
      key_size   <= SIZE_128;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_KEY_A:    key_word_a <= cfg_data;
        REG_KEY_B:    key_word_b <= cfg_data;
        REG_KEY_C:    key_word_c <= cfg_data;
        REG_KEY_D:    key_word_d <= cfg_data;
        REG_KEY_SIZE: key_size   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Round count and validity of the current size.
  logic [3:0]       cfg_nr;
  logic             cfg_bad;
  logic [3:0]       cfg_nk;
  logic [CNT_W-1:0] cfg_total;

  always_comb begin
    unique case (key_size)
      SIZE_128: cfg_nr = NR_128;
      SIZE_192: cfg_nr = NR_192;
      SIZE_256: cfg_nr = NR_256;
      default:  cfg_nr = 4'd0;
    endcase
    cfg_total = CNT_W'({2'b00, cfg_nr} + 6'd1) << 2;
    cfg_bad   = (cfg_nr == 4'd0) || (int'(cfg_total) > SCHEDULE_WORDS);
    cfg_nk    = cfg_nr - 4'd6;
  end

  // Key expansion sequencer.
  ks_state_t        ks_state, ks_state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] total;
  logic [2:0]       modc;
  logic [3:0]       act_nk;
  logic [3:0]       act_nr;
  logic             act_err;
  logic [7:0]       rcon;
  logic [31:0]      win [8];
  logic [31:0]      words [SCHEDULE_WORDS];
  logic [31:0]      kw [8];
  logic [31:0]      tmp, back, new_word;
  logic             restart;

  assign restart = cfg_write && cfg_hit;
  assign kw[0] = key_word_a[63:32];
  assign kw[1] = key_word_a[31:0];
  assign kw[2] = key_word_b[63:32];
  assign kw[3] = key_word_b[31:0];
  assign kw[4] = key_word_c[63:32];
  assign kw[5] = key_word_c[31:0];
  assign kw[6] = key_word_d[63:32];
  assign kw[7] = key_word_d[31:0];

  always_comb begin
    tmp = win[7];
    if (modc == 3'd0) begin
      tmp = sub_word({win[7][23:0], win[7][31:24]}) ^ {rcon, 24'h0};
    end else if (act_nk == 4'd8 && modc == 3'd4) begin
      tmp = sub_word(win[7]);
    end
    case (act_nk)
      4'd4:    back = win[4];
      4'd6:    back = win[2];
      default: back = win[0];
    endcase
    new_word = back ^ tmp;
  end

  always_comb begin
    ks_state_next = ks_state;
    unique case (ks_state)
      KS_LOAD: ks_state_next = cfg_bad ? KS_DONE : KS_RUN;
      KS_RUN:  if (cnt == total - CNT_W'(1)) ks_state_next = KS_DONE;
      KS_DONE: ks_state_next = KS_DONE;
      default: ks_state_next = KS_LOAD;
    endcase
    if (restart) ks_state_next = KS_LOAD;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ks_state <= KS_LOAD;
    end else begin
      ks_state <= ks_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ks_state == KS_LOAD) begin
      act_nr  <= cfg_nr;
      act_err <= cfg_bad;
      act_nk  <= cfg_nk;
      total   <= cfg_total;
      cnt     <= CNT_W'(cfg_nk);
      modc    <= 3'd0;
      rcon    <= 8'h01;
      for (int k = 0; k < 8; k++) begin
        win[k]   <= (k >= 8 - int'(cfg_nk)) ? kw[3'(k + int'(cfg_nk))] : 32'h0;
        words[k] <= kw[k];
      end
    end else if (ks_state == KS_RUN) begin
      for (int k = 0; k < 7; k++) begin
        win[k] <= win[k+1];
      end
      win[7]             <= new_word;
      words[cnt[AW-1:0]] <= new_word;
      cnt                <= cnt + CNT_W'(1);
      modc               <= (modc == 3'(act_nk - 4'd1)) ? 3'd0 : modc + 3'd1;
      if (modc == 3'd0) rcon <= xtime(rcon);
    end
  end

  // Round pipeline: stage 0 adds the first round key, stage r runs round r; later stages pass the state on.
  logic         en;
  logic         v   [STAGES];
  logic         er  [STAGES];
  logic [127:0] st  [STAGES];
  logic [127:0] rk  [STAGES];

  assign en       = !(v[STAGES-1] && out_stall);
  assign in_stall = !en || (ks_state != KS_DONE);

  for (genvar r = 0; r < STAGES; r++) begin : g_rk
    if (r < NROWS) begin : g_have
      assign rk[r] = {words[4*r], words[4*r+1], words[4*r+2], words[4*r+3]};
    end else begin : g_none
      assign rk[r] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid && !in_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= {plain_high, plain_low} ^ rk[0];
      er[0] <= act_err;
    end
  end

  for (genvar r = 1; r < STAGES; r++) begin : g_round
    logic [127:0] sb, full_out, last_out;

    always_comb begin
      sb       = sub_shift(st[r-1]);
      full_out = mix_columns(sb) ^ rk[r];
      last_out = sb ^ rk[r];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[r] <= 1'b0;
      end else if (en) begin
        v[r] <= v[r-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        er[r] <= er[r-1];
        if (4'(r) < act_nr) begin
          st[r] <= full_out;
        end else if (4'(r) == act_nr) begin
          st[r] <= last_out;
        end else begin
          st[r] <= st[r-1];
        end
      end
    end
  end

  // Zero the ciphertext of a word flagged with an unusable key.
  assign out_valid   = v[STAGES-1];
  assign key_error   = er[STAGES-1];
  assign cipher_high = er[STAGES-1] ? 64'h0 : st[STAGES-1][127:64];
  assign cipher_low  = er[STAGES-1] ? 64'h0 : st[STAGES-1][63:0];

endmodule

### hdl/aesenc_chk.sv
// Port-level checker for the AES encrypt unit, with its bind.
module aesenc_chk
  import aesenc_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 cfg_write,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [63:0]          cipher_high,
  input logic [63:0]          cipher_low,
  input logic                 key_error
);

  // Drop the pipeline contents on reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // A flagged word carries a zero ciphertext.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && key_error |-> cipher_high == 64'h0 && cipher_low == 64'h0)
    else $error("nonzero ciphertext with key error");

  // A key write starts expansion, so input must hold off.
  a_cfg_stall: assert property (@(posedge clk) disable iff (rst)
    cfg_write && (cfg_index == REG_KEY_A || cfg_index == REG_KEY_B ||
                  cfg_index == REG_KEY_C || cfg_index == REG_KEY_D ||
                  cfg_index == REG_KEY_SIZE) |=> in_stall)
    else $error("input accepted during key expansion");

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cipher_high) &&
                               $stable(cipher_low) && $stable(key_error))
    else $error("stalled output word changed");

endmodule

bind aes_block_encrypt_unit aesenc_chk u_aesenc_chk (
  .clk         (clk),
  .rst         (rst),
  .cfg_write   (cfg_write),
  .cfg_index   (cfg_index),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .cipher_high (cipher_high),
  .cipher_low  (cipher_low),
  .key_error   (key_error)
);

### bench/tb_aes_block_encrypt_unit.sv
// Self-checking testbench for the AES block encrypt unit.
module tb_aes_block_encrypt_unit;
  import aesenc_pkg::*;

  localparam int LATENCY     = 20;   // pipeline depth plus margin
  localparam int STALL_LIMIT = 6000; // cycles without any accepted word

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_t;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        err;
  } cipher_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]          cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [63:0]          plain_high = '0;
  logic [63:0]          plain_low = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b1;
  logic [63:0]          cipher_high;
  logic [63:0]          cipher_low;
  logic                 key_error;

  aes_block_encrypt_unit uut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
    .plain_high(plain_high), .plain_low(plain_low), .out_valid(out_valid),
    .out_stall(out_stall), .cipher_high(cipher_high), .cipher_low(cipher_low),
    .key_error(key_error)
  );

  // Shadow copy of the key registers and the expanded schedule.
  logic [63:0] key_a, key_b, key_c, key_d;
  logic [1:0]  key_len;
  logic [31:0] sched [SCHED_WORDS_DEF];
  logic        sched_valid;
  int          sched_rounds;

  block_t  plain_q[$];
  cipher_t cipher_expect_q[$];
  int      error_count = 0;
  int      idle_cycles = 0;
  int      send_gap = 0;
  int      recv_gap = 0;
  bit      no_idle = 0;    // phases with back-to-back traffic on both sides

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 55) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] gf_double(logic [7:0] x);
    gf_double = {x[6:0], 1'b0};
    if (x[7]) gf_double = gf_double ^ 8'h1b;
  endfunction

  function automatic logic [31:0] sbox_word(logic [31:0] w);
    for (int b = 0; b < 4; b++) sbox_word[8*b +: 8] = SBOX_TAB[w[8*b +: 8]];
  endfunction

  // Build the round-key schedule from the shadow key registers.
  function automatic void build_schedule(int nr);
    logic [31:0] kw [8];
    logic [31:0] t;
    logic [7:0]  rc;
    int          nk;
    nk = nr - 6;
    {kw[0], kw[1], kw[2], kw[3], kw[4], kw[5], kw[6], kw[7]} =
      {key_a, key_b, key_c, key_d};
    for (int i = 0; i < nk; i++) sched[i] = kw[i];
    for (int i = nk; i < 4 * (nr + 1); i++) begin
      t = sched[i-1];
      if (i % nk == 0) begin
        rc = 8'h01;
        for (int j = 1; j < i / nk; j++) rc = gf_double(rc);
        t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
      end else if (nk == 8 && i % 8 == 4) begin
        t = sbox_word(t);
      end
      sched[i] = sched[i-nk] ^ t;
    end
  endfunction

  // Expected ciphertext of one block under the current key setting.
  function automatic cipher_t aes_encrypt_block(block_t blk);
    logic [7:0]  st [16];
    logic [7:0]  tmp [16];
    logic [7:0]  a0, a1, a2, a3, all;
    logic [31:0] w;
    cipher_t     res;
    if (!sched_valid) begin
      case (key_len)
        SIZE_128: sched_rounds = int'(NR_128);
        SIZE_192: sched_rounds = int'(NR_192);
        SIZE_256: sched_rounds = int'(NR_256);
        default:  sched_rounds = 0;
      endcase
      if (4 * (sched_rounds + 1) > SCHED_WORDS_DEF) sched_rounds = 0;
      if (sched_rounds != 0) begin
        build_schedule(sched_rounds);
        sched_valid = 1'b1;
      end
    end
    if (!sched_valid) begin
      res = '{hi: '0, lo: '0, err: 1'b1};
      return res;
    end
    for (int i = 0; i < 16; i++) st[i] = blk[127 - 8*i -: 8];
    for (int r = 0; r <= sched_rounds; r++) begin
      if (r > 0) begin
        // substitute bytes and rotate rows
        for (int c = 0; c < 4; c++)
          for (int rw = 0; rw < 4; rw++)
            tmp[rw + 4*c] = SBOX_TAB[st[rw + 4*((c + rw) % 4)]];
        st = tmp;
        if (r < sched_rounds) begin
          for (int c = 0; c < 4; c++) begin
            a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            st[4*c]   = a0 ^ all ^ gf_double(a0 ^ a1);
            st[4*c+1] = a1 ^ all ^ gf_double(a1 ^ a2);
            st[4*c+2] = a2 ^ all ^ gf_double(a2 ^ a3);
            st[4*c+3] = a3 ^ all ^ gf_double(a3 ^ a0);
          end
        end
      end
      for (int c = 0; c < 4; c++) begin
        w = sched[4*r + c];
        for (int b = 0; b < 4; b++) st[4*c + b] = st[4*c + b] ^ w[31 - 8*b -: 8];
      end
    end
    for (int i = 0; i < 8; i++) begin
      res.hi[63 - 8*i -: 8] = st[i];
      res.lo[63 - 8*i -: 8] = st[8 + i];
    end
    res.err = 1'b0;
    return res;
  endfunction

  // Driver: advance to the next plain word once the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) cipher_expect_q.push_back(aes_encrypt_block({plain_high, plain_low}));
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (plain_q.size() > 0) begin
        {plain_high, plain_low} <= plain_q.pop_front();
        in_valid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each taken cipher word against the oldest expectation.
  always @(posedge clk) begin
    cipher_t exp_c;
    if (rst) begin
      out_stall <= 1'b1;
    end else begin
      if (out_valid && !out_stall) begin
        if (cipher_expect_q.size() == 0) begin
          $error("cipher word with no expectation: %h %h %b",
                 cipher_high, cipher_low, key_error);
          error_count++;
        end else begin
          exp_c = cipher_expect_q.pop_front();
          if (cipher_high !== exp_c.hi) begin
            $error("cipher_high expected %h actual %h", exp_c.hi, cipher_high);
            error_count++;
          end
          if (cipher_low !== exp_c.lo) begin
            $error("cipher_low expected %h actual %h", exp_c.lo, cipher_low);
            error_count++;
          end
          if (key_error !== exp_c.err) begin
            $error("key_error expected %b actual %b", exp_c.err, key_error);
            error_count++;
          end
        end
      end
      // hold stall for a random stretch, then drop it
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        recv_gap <= pick_gap();
      end
    end
  end

  // Watchdog: end the run when no word moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_KEY_A:    key_a = value;
      REG_KEY_B:    key_b = value;
      REG_KEY_C:    key_c = value;
      REG_KEY_D:    key_d = value;
      REG_KEY_SIZE: key_len = value[1:0];
      default:      ;
    endcase
    if (idx <= REG_KEY_SIZE) sched_valid = 1'b0;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic load_key(logic [63:0] a, logic [63:0] b, logic [63:0] c,
                          logic [63:0] d, logic [63:0] size_val);
    write_reg(REG_KEY_A, a);
    write_reg(REG_KEY_B, b);
    write_reg(REG_KEY_C, c);
    write_reg(REG_KEY_D, d);
    write_reg(REG_KEY_SIZE, size_val);
  endtask

  // Wait until every word is taken and answered, then let the pipeline drain.
  task automatic drain();
    wait (plain_q.size() == 0 && !in_valid && cipher_expect_q.size() == 0);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] edge_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 64'h8000_0000_0000_0000;
      3:       return 64'h0000_0000_0000_0001;
      default: return rand64();
    endcase
  endfunction

  initial begin
    logic [63:0] sz;
    int          count;
    key_a = '0; key_b = '0; key_c = '0; key_d = '0; key_len = SIZE_128;
    sched_valid = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed words under the reset key: field extremes, alternating bits and single set bits.
    plain_q.push_back('{hi: '0, lo: '0});
    plain_q.push_back('{hi: '1, lo: '1});
    plain_q.push_back('{hi: 64'haaaa_aaaa_aaaa_aaaa, lo: 64'h5555_5555_5555_5555});
    plain_q.push_back('{hi: 64'h0011_2233_4455_6677, lo: 64'h8899_aabb_ccdd_eeff});
    plain_q.push_back('{hi: 64'h8000_0000_0000_0000, lo: 64'h1});
    drain();

    // Standard test keys for every size, then an invalid size.
    load_key(64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f,
             64'h1011_1213_1415_1617, 64'h1819_1a1b_1c1d_1e1f, 64'(SIZE_128));
    plain_q.push_back('{hi: 64'h0011_2233_4455_6677, lo: 64'h8899_aabb_ccdd_eeff});
    plain_q.push_back('{hi: '1, lo: '0});
    drain();
    write_reg(REG_KEY_SIZE, 64'(SIZE_192));
    plain_q.push_back('{hi: 64'h0011_2233_4455_6677, lo: 64'h8899_aabb_ccdd_eeff});
    plain_q.push_back('{hi: '0, lo: '1});
    drain();
    write_reg(REG_KEY_SIZE, 64'(SIZE_256));
    plain_q.push_back('{hi: 64'h0011_2233_4455_6677, lo: 64'h8899_aabb_ccdd_eeff});
    plain_q.push_back('{hi: '1, lo: '1});
    drain();
    load_key('1, '1, '1, '1, 64'hffff_ffff_ffff_fffe); // wide value, 256-bit size
    plain_q.push_back('{hi: '0, lo: '0});
    drain();
    write_reg(REG_KEY_SIZE, 64'h3);                    // invalid size
    plain_q.push_back('{hi: '1, lo: '1});
    plain_q.push_back('{hi: 64'h1234, lo: 64'h5678});
    drain();
    // Writes past the last register must leave the setting alone.
    write_reg(3'd5, rand64());
    write_reg(3'd6, rand64());
    write_reg(3'd7, rand64());
    plain_q.push_back('{hi: 64'hdead_beef, lo: '0});
    drain();

    // Random phases: new key setting each time, random blocks under it.
    for (int ph = 0; ph < 12; ph++) begin
      no_idle = (ph % 4 == 3);
      sz = (ph % 6 == 5) ? rand64() : ((rand64() & ~64'h3) | 64'(ph % 3));
      load_key(edge_value(), edge_value(), edge_value(), edge_value(), sz);
      if ($urandom_range(0, 3) == 0) write_reg(3'(5 + $urandom_range(0, 2)), rand64());
      count = $urandom_range(45, 75);
      for (int n = 0; n < count; n++) begin
        plain_q.push_back('{hi: (n % 9 == 0) ? edge_value() : rand64(),
                           lo: (n % 11 == 0) ? edge_value() : rand64()});
        // pause the sender once mid-phase until every answer is back
        if (n == count / 2 && ph == 2) begin
          wait (plain_q.size() == 0 && !in_valid && cipher_expect_q.size() == 0);
        end
      end
      drain();
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
